// ===== rtl/range_min_sparse_table_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef RANGE_MIN_SPARSE_TABLE_UNIT_MACROS_SVH
`define RANGE_MIN_SPARSE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RMST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define RMST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rmst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rmst_pkg;

    // field widths
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 11;

    // default geometry
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int LEVELS_DEF      = 11;

    // size register reset value
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_BUILD = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // register word index
    localparam logic CFG_SIZE_IDX = 1'b0;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        start_index;
        logic [IDX_W-1:0]        end_index;
        logic signed [DATA_W-1:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] range_minimum;
        logic                     out_of_range;
    } out_item_t;

    // position of the highest set bit, zero for zero
    function automatic logic [4:0] floor_log2(input logic [31:0] v);
        logic [4:0] k;
        k = 5'd0;
        for (int b = 1; b < 32; b++) begin
            if (v[b]) begin
                k = 5'(b);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rmst_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/rmst_min.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmst_min (
    input  wire logic signed [rmst_pkg::DATA_W-1:0] a,
    input  wire logic signed [rmst_pkg::DATA_W-1:0] b,
    output logic      signed [rmst_pkg::DATA_W-1:0] y
);

    // signed minimum, shared by build and query
    assign y = (a < b) ? a : b;

endmodule

`default_nettype wire

// ===== rtl/rmst_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmst_seq #(
    parameter int MAX_ENTRIES = rmst_pkg::MAX_ENTRIES_DEF,
    parameter int LEVELS      = rmst_pkg::LEVELS_DEF,
    localparam int IW = $clog2(MAX_ENTRIES),
    localparam int LW = $clog2(LEVELS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire rmst_pkg::in_item_t          item_data,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output rmst_pkg::out_item_t              result_data,
    input  wire logic [rmst_pkg::SIZE_W-1:0] size_in_use,
    output logic                             ram_en,
    output logic                             ram_we,
    output logic [LW+IW-1:0]                 ram_addr,
    output logic [rmst_pkg::DATA_W-1:0]      ram_wdata,
    input  wire logic [rmst_pkg::DATA_W-1:0] ram_rdata
);

    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (NW > rmst_pkg::SIZE_W) ? NW : rmst_pkg::SIZE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_SKIP,
        S_B_INIT,
        S_B_RDA,
        S_B_RDB,
        S_B_WR,
        S_Q_SETUP,
        S_Q_RD1,
        S_Q_RD2,
        S_Q_CMP
    } state_t;

    state_t               state_reg;
    rmst_pkg::in_item_t   item_reg;
    rmst_pkg::out_item_t  result_reg;
    logic                 result_valid_reg;
    logic [LW-1:0]        k_reg;
    logic [LW-1:0]        top_reg;
    logic [CW-1:0]        i_reg;
    logic [CW-1:0]        delta_reg;
    logic [IW-1:0]        lo_reg;
    logic [IW-1:0]        second_reg;
    logic                 oor_reg;
    logic signed [rmst_pkg::DATA_W-1:0] a_reg;

    logic [CW-1:0]        size_w;
    logic [CW-1:0]        n_eff;
    logic [4:0]           top_raw;
    logic [LW-1:0]        top_cap;
    logic [rmst_pkg::IDX_W-1:0] lo_idx;
    logic [rmst_pkg::IDX_W-1:0] hi_idx;
    logic [rmst_pkg::IDX_W:0]   span;
    logic [4:0]           k_raw;
    logic [LW-1:0]        k_cap;
    logic [CW-1:0]        second_w;
    logic [CW-1:0]        next_i;
    logic [CW-1:0]        next_end;
    logic signed [rmst_pkg::DATA_W-1:0] min_val;
    logic                 result_free;
    logic                 accept;

    // effective table size, clamped to 1 .. MAX_ENTRIES
    always_comb
    begin
        size_w = CW'(size_in_use);
        if (size_w == '0)
        begin
            n_eff = CW'(1);
        end
        else if (size_w > CW'(MAX_ENTRIES))
        begin
            n_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            n_eff = size_w;
        end
    end

    // top level of the build
    always_comb
    begin
        top_raw = rmst_pkg::floor_log2(32'(n_eff));
        top_cap = (top_raw > 5'(LEVELS - 1)) ? LW'(LEVELS - 1) : LW'(top_raw);
    end

    // query range ordering, level and second position
    always_comb
    begin
        if (item_reg.start_index < item_reg.end_index)
        begin
            lo_idx = item_reg.start_index;
            hi_idx = item_reg.end_index;
        end
        else
        begin
            lo_idx = item_reg.end_index;
            hi_idx = item_reg.start_index;
        end
        span     = {1'b0, hi_idx} - {1'b0, lo_idx} + 11'd1;
        k_raw    = rmst_pkg::floor_log2(32'(span));
        k_cap    = (k_raw > 5'(LEVELS - 1)) ? LW'(LEVELS - 1) : LW'(k_raw);
        second_w = CW'(hi_idx) + CW'(1) - (CW'(1) << k_cap);
    end

    // build walk bookkeeping
    assign next_i   = i_reg + CW'(1);
    assign next_end = next_i + delta_reg;

    // shared compare unit
    rmst_min u_min (
        .a (a_reg),
        .b ($signed(ram_rdata)),
        .y (min_val)
    );

    assign result_free  = !result_valid_reg || !result_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // memory port
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = min_val;
        unique case (state_reg)
            S_WRITE:
            begin
                ram_en    = (CW'(item_reg.start_index) < n_eff);
                ram_we    = 1'b1;
                ram_addr  = {LW'(0), IW'(item_reg.start_index)};
                ram_wdata = item_reg.write_value;
            end
            S_B_RDA:
            begin
                ram_en   = 1'b1;
                ram_addr = {k_reg - LW'(1), i_reg[IW-1:0]};
            end
            S_B_RDB:
            begin
                ram_en   = 1'b1;
                ram_addr = {k_reg - LW'(1), IW'(i_reg + delta_reg)};
            end
            S_B_WR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = {k_reg, i_reg[IW-1:0]};
            end
            S_Q_RD1:
            begin
                ram_en   = !oor_reg;
                ram_addr = {k_reg, lo_reg};
            end
            S_Q_RD2:
            begin
                ram_en   = !oor_reg;
                ram_addr = {k_reg, second_reg};
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            item_reg         <= '0;
            k_reg            <= '0;
            top_reg          <= '0;
            i_reg            <= '0;
            delta_reg        <= '0;
            lo_reg           <= '0;
            second_reg       <= '0;
            oor_reg          <= 1'b0;
            a_reg            <= '0;
        end
        else
        begin
            // the compare step loads the next result itself
            if (result_valid_reg && !result_stall && (state_reg != S_Q_CMP))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= item_data;
                        unique case (item_data.mode)
                            rmst_pkg::MODE_WRITE: state_reg <= S_WRITE;
                            rmst_pkg::MODE_BUILD: state_reg <= S_B_INIT;
                            rmst_pkg::MODE_QUERY: state_reg <= S_Q_SETUP;
                            rmst_pkg::MODE_NONE:  state_reg <= S_SKIP;
                        endcase
                    end
                end
                S_WRITE:
                begin
                    state_reg <= S_IDLE;
                end
                S_SKIP:
                begin
                    state_reg <= S_IDLE;
                end
                S_B_INIT:
                begin
                    k_reg     <= LW'(1);
                    top_reg   <= top_cap;
                    i_reg     <= '0;
                    delta_reg <= CW'(1);
                    state_reg <= (top_cap == '0) ? S_IDLE : S_B_RDA;
                end
                S_B_RDA:
                begin
                    state_reg <= S_B_RDB;
                end
                S_B_RDB:
                begin
                    a_reg     <= $signed(ram_rdata);
                    state_reg <= S_B_WR;
                end
                S_B_WR:
                begin
                    if (next_end < n_eff)
                    begin
                        i_reg     <= next_i;
                        state_reg <= S_B_RDA;
                    end
                    else if (k_reg == top_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + LW'(1);
                        delta_reg <= delta_reg << 1;
                        i_reg     <= '0;
                        state_reg <= S_B_RDA;
                    end
                end
                S_Q_SETUP:
                begin
                    oor_reg    <= (CW'(hi_idx) >= n_eff);
                    lo_reg     <= IW'(lo_idx);
                    second_reg <= IW'(second_w);
                    k_reg      <= k_cap;
                    state_reg  <= S_Q_RD1;
                end
                S_Q_RD1:
                begin
                    state_reg <= S_Q_RD2;
                end
                S_Q_RD2:
                begin
                    a_reg     <= $signed(ram_rdata);
                    state_reg <= S_Q_CMP;
                end
                S_Q_CMP:
                begin
                    if (result_free)
                    begin
                        result_valid_reg         <= 1'b1;
                        result_reg.out_of_range  <= oor_reg;
                        result_reg.range_minimum <= oor_reg ? '0 : min_val;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/range_min_sparse_table_unit.sv =====
// Range-minimum sparse table over signed 32-bit values.
// Input channel item_valid / item_stall / item_data carries one item per
// handshake: mode write stores a base entry, mode build fills levels
// 1 .. floor(log2(size)) from level 0, mode query returns one result item on
// result_valid / result_stall / result_data. Unused mode 3 is dropped.
// The block takes one item at a time and stalls its input until done.
// A write or an unused-mode item passes through one state and returns to idle.
// A query runs setup, two reads of the single-port table memory and the
// compare step, which loads the result register once it is free, then idle.
// A build runs an init step, then for each of the size - 2^(k-1) entries of
// each level k one read, one read and one write of the table port.
// The size_in_use register sits at APB byte address 0; write it only while
// the block is idle. A query reads the table as left by the last build.
// Reset clears the control state and sets size_in_use to 1024; the table
// memory holds no reset value and must be written and built before use.
// A stalled result holds in its output register; the block still accepts
// a new item, and a following query waits at its final step until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none

module range_min_sparse_table_unit #(
    parameter int MAX_ENTRIES = rmst_pkg::MAX_ENTRIES_DEF,
    parameter int LEVELS      = rmst_pkg::LEVELS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire rmst_pkg::in_item_t          item_data,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output rmst_pkg::out_item_t              result_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int IW    = $clog2(MAX_ENTRIES);
    localparam int LW    = $clog2(LEVELS);
    localparam int DEPTH = LEVELS * (2 ** IW);

    logic [rmst_pkg::SIZE_W-1:0] size_reg;
    logic                        ram_en;
    logic                        ram_we;
    logic [LW+IW-1:0]            ram_addr;
    logic [rmst_pkg::DATA_W-1:0] ram_wdata;
    logic [rmst_pkg::DATA_W-1:0] ram_rdata;

    // size register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= rmst_pkg::SIZE_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == rmst_pkg::CFG_SIZE_IDX))
        begin
            size_reg <= pwdata[rmst_pkg::SIZE_W-1:0];
        end
    end

    // register readback
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rmst_pkg::CFG_SIZE_IDX) ? 32'(size_reg) : '0;

    rmst_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .LEVELS      (LEVELS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .size_in_use  (size_reg),
        .ram_en       (ram_en),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata)
    );

    // level table, row k holds level k
    rmst_ram #(
        .WIDTH (rmst_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/rmst_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "range_min_sparse_table_unit_macros.svh"

module rmst_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_stall,
    input wire logic                result_valid,
    input wire logic                result_stall,
    input wire rmst_pkg::out_item_t result_data
);

    // a stalled result holds
    `RMST_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_data), "stalled result item changed")

    // the block is busy right after taking an item
    `RMST_ASSERT_NXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "input not stalled after item accepted")

    // an out-of-range answer carries a zero minimum
    `RMST_ASSERT_IMP(a_oor_zero, result_valid && result_data.out_of_range, result_data.range_minimum == '0, "out-of-range result with nonzero minimum")

    // a new result only appears at the end of a busy query
    `RMST_ASSERT_IMP(a_result_from_busy, $rose(result_valid), $past(item_stall), "result item appeared while idle")

endmodule

bind range_min_sparse_table_unit rmst_checker u_rmst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

`default_nettype wire
